// ===== hw/rtl/kmq_pkg.sv =====
// Shared types for the gray-level k-means quantizer.
`default_nettype none
package kmq_pkg;

	typedef enum logic [3:0] {
		ST_INIT,
		ST_IDLE,
		ST_CLR,
		ST_SCAN,
		ST_ACC_RD,
		ST_ACC_WR,
		ST_UPD_RD,
		ST_UPD_CHK,
		ST_UPD_DIV,
		ST_RND_END,
		ST_CLS_OUT,
		ST_EMIT_RD,
		ST_EMIT_WR
	} st_t;

	localparam logic CMD_TRAIN    = 1'b0;
	localparam logic CMD_CLASSIFY = 1'b1;

endpackage
`default_nettype wire

// ===== hw/rtl/gray_level_kmeans_quantizer.sv =====
// Top level of the gray-level k-means quantizer: sequencer, memories and output register.
//
// Input channel (in_valid, in_stall, command, pixel) takes one command at a time.
// A classify command scans the centroid memory one entry per cycle. Its one item, the
// nearest centroid index and value with last = 1, is loaded into the output register
// once the scan ends and the register is free; the next command can be taken once it is valid.
// A train command reloads the start centroids, then runs rounds.
// Each round runs the sum clear, the one-entry-per-cycle scan for each level with its
// accumulate step, and the bit-serial divider for each cluster that holds levels.
// At most MAX_ROUNDS rounds run. Training then returns NUM_CLUSTERS items in index
// order, each waiting while out_stall is high, the final one with last = 1.
// in_stall is high whenever a command is in progress.
// After reset the block writes the start centroids with in_stall high; a classify
// before any training uses them.
// The result sits in an output register; while out_stall is high it holds and the
// sequencer waits before it writes the next item.
`default_nettype none
module gray_level_kmeans_quantizer #(
	parameter int NUM_CLUSTERS = 16,
	parameter int NUM_LEVELS   = 256,
	parameter int MAX_ROUNDS   = 64
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output      logic       in_stall,
	input  wire logic       command,
	input  wire logic [7:0] pixel,
	output      logic       out_valid,
	input  wire logic       out_stall,
	output      logic [3:0] cluster_index,
	output      logic [7:0] centroid_value,
	output      logic       converged,
	output      logic       last
);

	localparam int KW   = $clog2(NUM_CLUSTERS);
	localparam int KCW  = $clog2(NUM_CLUSTERS + 1);
	localparam int LW   = $clog2(NUM_LEVELS);
	localparam int XW   = (LW > 8) ? LW : 8;
	localparam int SW   = $clog2(NUM_LEVELS * (NUM_LEVELS - 1) / 2 + 1);
	localparam int CW   = $clog2(NUM_LEVELS + 1);
	localparam int MAXV = (NUM_LEVELS - 1 < 255) ? NUM_LEVELS - 1 : 255;

	kmq_pkg::st_t st_q, st_n;

	logic [KCW-1:0] k_q;
	logic [LW-1:0]  lvl_q;
	logic           mode_q;
	logic [7:0]     pix_q;
	logic           train_q;
	logic [XW-1:0]  bd_q;
	logic [KW-1:0]  bi_q;
	logic [7:0]     bv_q;
	logic [7:0]     c_q;
	logic           changed_q;
	logic [6:0]     round_q;

	logic           out_valid_q;
	logic [3:0]     idx_q;
	logic [7:0]     val_q;
	logic           conv_q;
	logic           last_q;

	logic           in_acc;
	logic           out_free;
	logic           out_load;
	logic [3:0]     idx_n;
	logic           last_n;

	logic           cent_we;
	logic [KW-1:0]  cent_waddr;
	logic [7:0]     cent_wdata;
	logic [KW-1:0]  cent_raddr;
	logic [7:0]     cent_rd;

	logic            sum_we;
	logic [KW-1:0]   sum_addr;
	logic [SW+CW-1:0] sum_wdata;
	logic [SW+CW-1:0] sum_rd;
	logic [SW-1:0]   sum_val;
	logic [CW-1:0]   cnt_val;

	logic           div_start;
	logic           div_busy;
	logic           div_done;
	logic [SW-1:0]  div_q;
	logic [SW+8:0]  div_ext;
	logic [7:0]     mean;

	logic [KW-1:0]  kidx;
	logic [KCW-1:0] scan_idx;
	logic [XW-1:0]  x_val;
	logic [XW-1:0]  c_ext;
	logic [XW-1:0]  delta;
	logic           k_last;
	logic           lvl_last;
	logic [7:0]     start_v;
	logic [KW+3:0]  bi_ext;
	logic [KW+3:0]  k_ext;
	logic [7:0]     round_inc;

	kmq_ram #(.WIDTH(8), .DEPTH(NUM_CLUSTERS)) u_cent_ram (
		.clk   (clk),
		.we    (cent_we),
		.waddr (cent_waddr),
		.wdata (cent_wdata),
		.raddr (cent_raddr),
		.rdata (cent_rd)
	);

	kmq_ram #(.WIDTH(SW + CW), .DEPTH(NUM_CLUSTERS)) u_sum_ram (
		.clk   (clk),
		.we    (sum_we),
		.waddr (sum_addr),
		.wdata (sum_wdata),
		.raddr (sum_addr),
		.rdata (sum_rd)
	);

	kmq_div #(.NW(SW), .DW(CW)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (sum_val),
		.divisor  (cnt_val),
		.busy     (div_busy),
		.done     (div_done),
		.quotient (div_q)
	);

	assign kidx     = k_q[KW-1:0];
	assign scan_idx = k_q - 1'b1;
	assign k_last   = (k_q == KCW'(NUM_CLUSTERS - 1));
	assign lvl_last = (lvl_q == LW'(NUM_LEVELS - 1));
	assign x_val    = (mode_q == kmq_pkg::CMD_CLASSIFY) ? XW'(pix_q) : XW'(lvl_q);
	assign c_ext    = XW'(cent_rd);
	assign delta    = (x_val > c_ext) ? x_val - c_ext : c_ext - x_val;
	assign sum_val  = sum_rd[SW+CW-1:CW];
	assign cnt_val  = sum_rd[CW-1:0];
	assign div_ext  = (SW + 9)'(div_q);
	assign mean     = (div_ext > (SW + 9)'(255)) ? 8'd255 : div_ext[7:0];
	assign start_v  = (16 * int'(k_q) + 3 > MAXV) ? 8'(MAXV) : 8'(16 * int'(k_q) + 3);
	assign bi_ext   = (KW + 4)'(bi_q);
	assign k_ext    = (KW + 4)'(kidx);
	assign round_inc = {1'b0, round_q} + 8'd1;

	assign in_acc   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		st_n = st_q;
		unique case (st_q)
			kmq_pkg::ST_INIT: begin
				if (k_last) begin
					st_n = train_q ? kmq_pkg::ST_CLR : kmq_pkg::ST_IDLE;
				end
			end
			kmq_pkg::ST_IDLE: begin
				if (in_acc) begin
					st_n = (command == kmq_pkg::CMD_CLASSIFY) ? kmq_pkg::ST_SCAN
						: kmq_pkg::ST_INIT;
				end
			end
			kmq_pkg::ST_CLR: begin
				if (k_last) begin
					st_n = kmq_pkg::ST_SCAN;
				end
			end
			kmq_pkg::ST_SCAN: begin
				if (k_q == KCW'(NUM_CLUSTERS)) begin
					st_n = (mode_q == kmq_pkg::CMD_CLASSIFY) ? kmq_pkg::ST_CLS_OUT
						: kmq_pkg::ST_ACC_RD;
				end
			end
			kmq_pkg::ST_ACC_RD: st_n = kmq_pkg::ST_ACC_WR;
			kmq_pkg::ST_ACC_WR: st_n = lvl_last ? kmq_pkg::ST_UPD_RD : kmq_pkg::ST_SCAN;
			kmq_pkg::ST_UPD_RD: st_n = kmq_pkg::ST_UPD_CHK;
			kmq_pkg::ST_UPD_CHK: begin
				if (cnt_val != '0) begin
					st_n = kmq_pkg::ST_UPD_DIV;
				end else begin
					st_n = k_last ? kmq_pkg::ST_RND_END : kmq_pkg::ST_UPD_RD;
				end
			end
			kmq_pkg::ST_UPD_DIV: begin
				if (div_done) begin
					st_n = k_last ? kmq_pkg::ST_RND_END : kmq_pkg::ST_UPD_RD;
				end
			end
			kmq_pkg::ST_RND_END: begin
				st_n = (changed_q && round_inc < 8'(MAX_ROUNDS)) ? kmq_pkg::ST_CLR
					: kmq_pkg::ST_EMIT_RD;
			end
			kmq_pkg::ST_CLS_OUT: begin
				if (out_free) begin
					st_n = kmq_pkg::ST_IDLE;
				end
			end
			kmq_pkg::ST_EMIT_RD: st_n = kmq_pkg::ST_EMIT_WR;
			kmq_pkg::ST_EMIT_WR: begin
				if (out_free) begin
					st_n = k_last ? kmq_pkg::ST_IDLE : kmq_pkg::ST_EMIT_RD;
				end
			end
			default: st_n = kmq_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_stall   = (st_q != kmq_pkg::ST_IDLE);
		cent_we    = 1'b0;
		cent_waddr = kidx;
		cent_wdata = start_v;
		cent_raddr = kidx;
		sum_we     = 1'b0;
		sum_addr   = kidx;
		sum_wdata  = '0;
		div_start  = 1'b0;
		out_load   = 1'b0;
		idx_n      = k_ext[3:0];
		last_n     = k_last;
		unique case (st_q)
			kmq_pkg::ST_INIT: begin
				cent_we = 1'b1;
			end
			kmq_pkg::ST_CLR: begin
				sum_we = 1'b1;
			end
			kmq_pkg::ST_ACC_RD: begin
				sum_addr = bi_q;
			end
			kmq_pkg::ST_ACC_WR: begin
				sum_addr  = bi_q;
				sum_we    = 1'b1;
				sum_wdata = {sum_val + SW'(lvl_q), cnt_val + 1'b1};
			end
			kmq_pkg::ST_UPD_CHK: begin
				div_start = (cnt_val != '0);
			end
			kmq_pkg::ST_UPD_DIV: begin
				cent_we    = div_done;
				cent_wdata = mean;
			end
			kmq_pkg::ST_CLS_OUT: begin
				out_load = out_free;
				idx_n    = bi_ext[3:0];
				last_n   = 1'b1;
			end
			kmq_pkg::ST_EMIT_WR: begin
				out_load = out_free;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= kmq_pkg::ST_INIT;
			k_q       <= '0;
			lvl_q     <= '0;
			mode_q    <= kmq_pkg::CMD_TRAIN;
			train_q   <= 1'b0;
			changed_q <= 1'b0;
			round_q   <= '0;
		end else begin
			st_q <= st_n;
			unique case (st_q)
				kmq_pkg::ST_INIT: begin
					k_q     <= k_last ? '0 : k_q + 1'b1;
					round_q <= '0;
				end
				kmq_pkg::ST_IDLE: begin
					k_q <= '0;
					if (in_acc) begin
						mode_q  <= command;
						train_q <= (command == kmq_pkg::CMD_TRAIN);
					end
				end
				kmq_pkg::ST_CLR: begin
					k_q       <= k_last ? '0 : k_q + 1'b1;
					lvl_q     <= '0;
					changed_q <= 1'b0;
				end
				kmq_pkg::ST_SCAN: begin
					k_q <= (k_q == KCW'(NUM_CLUSTERS)) ? '0 : k_q + 1'b1;
				end
				kmq_pkg::ST_ACC_WR: begin
					lvl_q <= lvl_q + 1'b1;
				end
				kmq_pkg::ST_UPD_CHK: begin
					if (cnt_val == '0) begin
						k_q <= k_last ? '0 : k_q + 1'b1;
					end
				end
				kmq_pkg::ST_UPD_DIV: begin
					if (div_done) begin
						k_q <= k_last ? '0 : k_q + 1'b1;
						if (mean != c_q) begin
							changed_q <= 1'b1;
						end
					end
				end
				kmq_pkg::ST_RND_END: begin
					round_q <= round_inc[6:0];
				end
				kmq_pkg::ST_EMIT_WR: begin
					if (out_free) begin
						k_q <= k_last ? '0 : k_q + 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == kmq_pkg::ST_IDLE && in_acc) begin
			pix_q <= pixel;
		end
		if (st_q == kmq_pkg::ST_SCAN && k_q != '0) begin
			if (k_q == KCW'(1) || delta < bd_q) begin
				bd_q <= delta;
				bi_q <= scan_idx[KW-1:0];
				bv_q <= cent_rd;
			end
		end
		if (st_q == kmq_pkg::ST_UPD_CHK) begin
			c_q <= cent_rd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			idx_q  <= idx_n;
			val_q  <= (st_q == kmq_pkg::ST_CLS_OUT) ? bv_q : cent_rd;
			conv_q <= (st_q == kmq_pkg::ST_CLS_OUT) ? 1'b0 : !changed_q;
			last_q <= last_n;
		end
	end

	assign out_valid      = out_valid_q;
	assign cluster_index  = idx_q;
	assign centroid_value = val_q;
	assign converged      = conv_q;
	assign last           = last_q;

	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_busy)
		else $error("Divider started while busy.");

	a_no_wr_on_load: assert property (@(posedge clk) disable iff (!arst_n)
		cent_we |-> !out_load)
		else $error("Centroid write during an output load.");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> (!out_valid_q || !out_stall))
		else $error("Output register overwritten while stalled.");

	a_idle_k: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == kmq_pkg::ST_IDLE) |-> (k_q == '0) || $past(st_q == kmq_pkg::ST_IDLE))
		else $error("Index counter not cleared on return to idle.");

endmodule
`default_nettype wire

// ===== hw/rtl/kmq_ram.sv =====
// Generic single-write, single-read RAM with a registered read.
`default_nettype none
module kmq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

// ===== hw/rtl/kmq_div.sv =====
// Restoring divider that produces one quotient bit per cycle.
`default_nettype none
module kmq_div #(
	parameter int NW = 16,
	parameter int DW = 9
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic [NW-1:0] dividend,
	input  wire logic [DW-1:0] divisor,
	output      logic          busy,
	output      logic          done,
	output      logic [NW-1:0] quotient
);

	localparam int CNTW = $clog2(NW + 1);

	logic [CNTW-1:0] cnt_q;
	logic [DW:0]     rem_q;
	logic [NW-1:0]   num_q;
	logic [DW-1:0]   den_q;
	logic            busy_q;
	logic            done_q;
	logic [DW:0]     trial;
	logic [DW:0]     den_ext;

	assign den_ext = {1'b0, den_q};
	assign trial   = {rem_q[DW-1:0], num_q[NW-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNTW'(NW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNTW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			num_q <= dividend;
			den_q <= divisor;
		end else if (busy_q) begin
			if (trial >= den_ext) begin
				rem_q <= trial - den_ext;
				num_q <= {num_q[NW-2:0], 1'b1};
			end else begin
				rem_q <= trial;
				num_q <= {num_q[NW-2:0], 1'b0};
			end
		end
	end

	assign busy     = busy_q;
	assign done     = done_q;
	assign quotient = num_q;

endmodule
`default_nettype wire

// ===== test/gray_level_kmeans_quantizer_tb.sv =====
// Testbench for the gray-level k-means quantizer: random classify and train traffic.
`default_nettype none
module gray_level_kmeans_quantizer_tb;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [3:0] index;
		logic [7:0] value;
		logic       conv;
		logic       fin;
	} cluster_result_t;

	class kmq_scoreboard;
		logic [7:0] centers[16];
		cluster_result_t pending_results[$];
		int mismatches;
		int checked;
		int trains;
		int classifies;
		int unconverged;

		function new();
			load_start_centers();
		endfunction

		function void load_start_centers();
			int v;
			for (int k = 0; k < 16; k++) begin
				v = 16 * k + 3;
				if (v > 255)
					v = 255;
				centers[k] = v[7:0];
			end
		endfunction

		function int nearest_center(int x);
			int best;
			int bd;
			int d;
			best = 0;
			bd = (x > centers[0]) ? x - centers[0] : centers[0] - x;
			for (int k = 1; k < 16; k++) begin
				d = (x > centers[k]) ? x - centers[k] : centers[k] - x;
				if (d < bd) begin
					bd = d;
					best = k;
				end
			end
			return best;
		endfunction

		function bit run_training();
			int sums[16];
			int counts[16];
			int rounds;
			int j;
			int m;
			bit moved;
			load_start_centers();
			rounds = 0;
			do begin
				for (int k = 0; k < 16; k++) begin
					sums[k] = 0;
					counts[k] = 0;
				end
				for (int lvl = 0; lvl < 256; lvl++) begin
					j = nearest_center(lvl);
					sums[j] += lvl;
					counts[j]++;
				end
				moved = 0;
				for (int k = 0; k < 16; k++) begin
					if (counts[k] != 0) begin
						m = sums[k] / counts[k];
						if (m > 255)
							m = 255;
						if (m != centers[k])
							moved = 1;
						centers[k] = m[7:0];
					end
				end
				rounds++;
			end while (moved && rounds < 64);
			return !moved;
		endfunction

		function void note_item(logic cmd, logic [7:0] pix);
			cluster_result_t r;
			bit conv;
			int j;
			if (cmd == kmq_pkg::CMD_CLASSIFY) begin
				classifies++;
				j = nearest_center(int'(pix));
				r.index = j[3:0];
				r.value = centers[j];
				r.conv = 1'b0;
				r.fin = 1'b1;
				pending_results.push_back(r);
			end else begin
				trains++;
				conv = run_training();
				if (!conv)
					unconverged++;
				for (int k = 0; k < 16; k++) begin
					r.index = k[3:0];
					r.value = centers[k];
					r.conv = conv;
					r.fin = (k == 15);
					pending_results.push_back(r);
				end
			end
		endfunction

		function void check_result(cluster_result_t got);
			cluster_result_t want;
			checked++;
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("Unexpected result: index %0d value %0d converged %0b last %0b",
						got.index, got.value, got.conv, got.fin);
				return;
			end
			want = pending_results.pop_front();
			if (got !== want) begin
				mismatches++;
				if (mismatches <= 10)
					$display("Mismatch: expected index %0d value %0d converged %0b last %0b,",
						want.index, want.value, want.conv, want.fin,
						" got index %0d value %0d converged %0b last %0b",
						got.index, got.value, got.conv, got.fin);
			end
		endfunction
	endclass

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic       command = kmq_pkg::CMD_CLASSIFY;
	logic [7:0] pixel = 8'd0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [3:0] cluster_index;
	logic [7:0] centroid_value;
	logic       converged;
	logic       last;

	kmq_scoreboard sb = new();
	int burst_left = 0;
	int stall_mode = 0;
	int stall_cycles = 0;
	int train_budget = 2;

	gray_level_kmeans_quantizer dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.command(command),
		.pixel(pixel),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.cluster_index(cluster_index),
		.centroid_value(centroid_value),
		.converged(converged),
		.last(last)
	);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		if (stall_cycles == 0) begin
			stall_mode <= $urandom_range(0, 2);
			stall_cycles <= $urandom_range(20, 120);
		end else begin
			stall_cycles <= stall_cycles - 1;
		end
		case (stall_mode)
			0: out_stall <= 1'b0;
			1: out_stall <= ($urandom_range(0, 3) == 0);
			default: out_stall <= ($urandom_range(0, 3) != 0);
		endcase
	end

	always @(negedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_result({cluster_index, centroid_value, converged, last});
	end

	task automatic send_item(input logic cmd, input logic [7:0] pix);
		int gap;
		bit taken;
		if (burst_left == 0) begin
			in_valid <= 1'b0;
			gap = $urandom_range(1, 12);
			repeat (gap) @(posedge clk);
			burst_left = $urandom_range(1, 30);
		end
		in_valid <= 1'b1;
		command <= cmd;
		pixel <= pix;
		do begin
			@(negedge clk);
			taken = !in_stall;
			@(posedge clk);
		end while (!taken);
		sb.note_item(cmd, pix);
		burst_left--;
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		burst_left = 0;
		while (sb.pending_results.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		#200_000_000;
		$display("gray_level_kmeans_quantizer_tb NOT OK");
		$finish;
	end

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Classification with the reset centroids, including a tie between two centroids.
		send_item(kmq_pkg::CMD_CLASSIFY, 8'd0);
		send_item(kmq_pkg::CMD_CLASSIFY, 8'd255);
		send_item(kmq_pkg::CMD_CLASSIFY, 8'd11);
		send_item(kmq_pkg::CMD_CLASSIFY, 8'd3);
		send_item(kmq_pkg::CMD_CLASSIFY, 8'd170);
		send_item(kmq_pkg::CMD_TRAIN, 8'd0);
		send_item(kmq_pkg::CMD_CLASSIFY, 8'd0);
		send_item(kmq_pkg::CMD_CLASSIFY, 8'd255);
		send_item(kmq_pkg::CMD_CLASSIFY, 8'd128);
		send_item(kmq_pkg::CMD_CLASSIFY, 8'd127);
		send_item(kmq_pkg::CMD_CLASSIFY, 8'h55);
		send_item(kmq_pkg::CMD_CLASSIFY, 8'hAA);
		send_item(kmq_pkg::CMD_TRAIN, 8'hFF);
		for (int p = 0; p < 8; p++)
			send_item(kmq_pkg::CMD_CLASSIFY, 8'd1 << p);

		for (int n = 0; n < 500; n++) begin
			if (n == 250)
				wait_drained();
			if (train_budget > 0 && $urandom_range(0, 199) == 0) begin
				train_budget--;
				send_item(kmq_pkg::CMD_TRAIN, 8'($urandom_range(0, 255)));
			end else begin
				send_item(kmq_pkg::CMD_CLASSIFY, 8'($urandom_range(0, 255)));
			end
		end

		wait_drained();
		repeat (40) @(posedge clk);
		$display("Covered %0d classify and %0d train items, %0d results checked.",
			sb.classifies, sb.trains, sb.checked);
		$display("Trainings ended by the round limit: %0d; mismatches: %0d.",
			sb.unconverged, sb.mismatches);
		if (sb.mismatches == 0 && sb.pending_results.size() == 0)
			$display("gray_level_kmeans_quantizer_tb OK");
		else
			$display("gray_level_kmeans_quantizer_tb NOT OK");
		$finish;
	end
endmodule
`default_nettype wire
